FILE: rtl/core/plcg64_pkg.sv
// ----------------------------------------------------------------------------
// plcg64_pkg
// Constants and types shared by the prime modulus 64-bit generator.
// ----------------------------------------------------------------------------
package plcg64_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
  localparam int unsigned PROD_W     = WORD_W + DIGIT_W;
  // accumulator keeps two guard bits, the running value stays congruent
  localparam int unsigned ACC_W      = WORD_W + 2;
  localparam int unsigned HI_W       = ACC_W - (WORD_W - DIGIT_W);
  localparam int unsigned HSUM_W     = HI_W + 1;
  localparam int unsigned HMUL_W     = HSUM_W + 6;

  localparam logic [WORD_W-1:0] LCG_MULT   = 64'd13891176665706064842;
  localparam logic [WORD_W-1:0] LCG_MOD    = 64'd18446744073709551557;
  localparam logic [5:0]        LCG_FOLD   = 6'd59;
  localparam logic [WORD_W-1:0] SEED_FORCE = 64'h1;
  localparam logic [WORD_W-1:0] STATE_INIT = 64'h1;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_FOLD,
    ST_CARRY,
    ST_SUB,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/plcg64_if.sv
// ----------------------------------------------------------------------------
// plcg64 channel interfaces
// Request channel (operation and seed) and response channel (random word).
// ----------------------------------------------------------------------------
interface plcg64_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface plcg64_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

FILE: rtl/core/prime_modulus_lcg64.sv
// ----------------------------------------------------------------------------
// prime_modulus_lcg64
// Multiplicative generator modulo 2^64-59, digit-serial multiply and fold.
//
//   channel | dir | word
//   --------+-----+------------------------------------------
//   req     | in  | operation (step / load), seed_value[63:0]
//   rsp     | out | random_word[63:0], one per request
//
// a step feeds four 16-bit digits through the 64x16 constant multiplier,
// then a drain step, then fold, carry and final subtract of the modulus;
// a load writes the seed straight to the result.
// results sit in an output register, so the next word is accepted while a
// result waits; a finished result waits in ST_DONE if the register is full.
// synchronous reset sets the state word to one and empties the output.
// ----------------------------------------------------------------------------
module prime_modulus_lcg64 (
  input  logic         clk,
  input  logic         rst,
  plcg64_req_if.sink   req,
  plcg64_rsp_if.source rsp
);
  import plcg64_pkg::*;

  state_t state, state_next;

  logic [WORD_W-1:0] gen_state;
  logic [WORD_W-1:0] sh;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] res;

  logic start_step, start_load, acc_en, rsp_load;

  logic [HSUM_W-1:0] hsum;
  logic [HMUL_W-1:0] hmul;
  logic [ACC_W-1:0]  acc_step;
  logic [ACC_W-1:0]  acc_fold;
  logic [WORD_W-1:0] acc_carry;
  logic [WORD_W-1:0] acc_sub;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (op_t'(req.operation) == OP_LOAD) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == CNT_W'(NUM_DIGITS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FOLD;
      ST_FOLD:  state_next = ST_CARRY;
      ST_CARRY: state_next = ST_SUB;
      ST_SUB:   state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready  = !rst && (state == ST_IDLE);
    start_step = req.ready && req.valid && (op_t'(req.operation) == OP_STEP);
    start_load = req.ready && req.valid && (op_t'(req.operation) == OP_LOAD);
    // the product of digit k is added in the cycle after it is formed
    acc_en     = ((state == ST_MUL) && (cnt != '0)) || (state == ST_DRAIN);
    rsp_load   = (state == ST_DONE) && (!rsp.valid || rsp.ready);
  end

  // acc*2^16 + prod, with the part above 2^64 folded back as 59*high
  always_comb begin
    hsum     = HSUM_W'(acc[ACC_W-1:WORD_W-DIGIT_W]) + HSUM_W'(prod[PROD_W-1:WORD_W]);
    hmul     = HMUL_W'(hsum) * HMUL_W'(LCG_FOLD);
    acc_step = ACC_W'({acc[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}})
             + ACC_W'(prod[WORD_W-1:0]) + ACC_W'(hmul);
    acc_fold = ACC_W'(acc[WORD_W-1:0]) + ACC_W'(8'(acc[ACC_W-1:WORD_W]) * 8'(LCG_FOLD));
    // after the fold a carry leaves a small low word, so this cannot wrap
    acc_carry = acc[WORD_W-1:0] + (acc[WORD_W] ? WORD_W'(LCG_FOLD) : '0);
    acc_sub   = (acc[WORD_W-1:0] >= LCG_MOD) ? (acc[WORD_W-1:0] - LCG_MOD)
                                             : acc[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gen_state <= STATE_INIT;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_step) begin
        cnt <= '0;
      end else if (state == ST_MUL) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (start_load) begin
        gen_state <= req.seed_value | SEED_FORCE;
      end else if (state == ST_SUB) begin
        gen_state <= acc_sub;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_step) begin
      sh  <= gen_state;
      acc <= '0;
    end else begin
      if (state == ST_MUL) begin
        sh <= {sh[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
      if (acc_en) begin
        acc <= acc_step;
      end else if (state == ST_FOLD) begin
        acc <= acc_fold;
      end else if (state == ST_CARRY) begin
        acc <= ACC_W'(acc_carry);
      end
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(LCG_MULT) * PROD_W'(sh[WORD_W-1:WORD_W-DIGIT_W]);
    end
    if (start_load) begin
      res <= req.seed_value | SEED_FORCE;
    end else if (state == ST_SUB) begin
      res <= acc_sub;
    end
    if (rsp_load) begin
      rsp.random_word <= res;
    end
  end

`ifndef ASSERT_OFF
  // a finished step is always fully reduced
  a_step_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUB |=> res < LCG_MOD)
    else $error("step result not below modulus");

  // the fold leaves at most one bit above the word
  a_fold_width: assert property (@(posedge clk) disable iff (rst)
    state == ST_CARRY |-> acc[ACC_W-1] == 1'b0)
    else $error("fold left accumulator too wide");

  // an accepted word starts either the multiply or a direct load
  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_MUL || state == ST_DONE)
    else $error("accepted word took no path");

  // the output register is written only when it is free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> !rsp.valid || rsp.ready)
    else $error("pending result overwritten");
`endif

endmodule
